/* rtl/kfpt_pkg.sv */
// kfpt_pkg: types, codes and reset values shared by the kiln firing phase tracker
// no dependencies; every rtl file uses it by scoped names

package kfpt_pkg;

  localparam int TempW = 16;
  localparam int CntW = 16;
  localparam int TickW = 32;
  localparam int NumProbes = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RESTING  = 3'd1,
    PH_PREHEAT  = 3'd2,
    PH_ACTIVE   = 3'd3,
    PH_COOLDOWN = 3'd4,
    PH_COMPLETE = 3'd5
  } phase_t;

  // vote rules; the unused code behaves as majority
  localparam logic [1:0] VOTE_ANY = 2'd0;
  localparam logic [1:0] VOTE_ALL = 2'd1;
  localparam logic [1:0] VOTE_MAJ = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PREHEAT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ACTIVATE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COOL     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RULE     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REST_TO  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_COOL_NEED = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ABANDON  = 3'd6;

  localparam logic signed [TempW-1:0] RST_PREHEAT  = 16'sd800;
  localparam logic signed [TempW-1:0] RST_ACTIVATE = 16'sd3200;
  localparam logic signed [TempW-1:0] RST_COOL     = 16'sd2400;
  localparam logic [1:0]              RST_RULE     = VOTE_MAJ;
  localparam logic [CntW-1:0]         RST_REST_TO  = 16'd300;
  localparam logic [CntW-1:0]         RST_COOL_NEED = 16'd10;
  localparam logic [CntW-1:0]         RST_ABANDON  = 16'd15;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic                    ok;
  } probe_t;

  typedef struct packed {
    logic signed [TempW-1:0] preheat;
    logic signed [TempW-1:0] activate;
    logic signed [TempW-1:0] cool;
    logic [1:0]              rule;
    logic [CntW-1:0]         rest_to;
    logic [CntW-1:0]         cool_need;
    logic [CntW-1:0]         abandon;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic             heat;
    logic             session;
    logic [TickW-1:0] ticks;
  } result_t;

endpackage

/* rtl/kfpt_cfg_regs.sv */
// kfpt_cfg_regs: configuration registers of the phase tracker, write-only port
// depends on kfpt_pkg

module kfpt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kfpt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [kfpt_pkg::CfgDataW-1:0]  cfg_data,
  output kfpt_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preheat   <= kfpt_pkg::RST_PREHEAT;
      cfg.activate  <= kfpt_pkg::RST_ACTIVATE;
      cfg.cool      <= kfpt_pkg::RST_COOL;
      cfg.rule      <= kfpt_pkg::RST_RULE;
      cfg.rest_to   <= kfpt_pkg::RST_REST_TO;
      cfg.cool_need <= kfpt_pkg::RST_COOL_NEED;
      cfg.abandon   <= kfpt_pkg::RST_ABANDON;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kfpt_pkg::REG_PREHEAT:   cfg.preheat   <= $signed(cfg_data);
        kfpt_pkg::REG_ACTIVATE:  cfg.activate  <= $signed(cfg_data);
        kfpt_pkg::REG_COOL:      cfg.cool      <= $signed(cfg_data);
        kfpt_pkg::REG_RULE:      cfg.rule      <= cfg_data[1:0];
        kfpt_pkg::REG_REST_TO:   cfg.rest_to   <= cfg_data;
        kfpt_pkg::REG_COOL_NEED: cfg.cool_need <= cfg_data;
        kfpt_pkg::REG_ABANDON:   cfg.abandon   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/kfpt_vote.sv */
// kfpt_vote: votes the valid probes against one threshold by any, all or majority
// depends on kfpt_pkg

module kfpt_vote (
  input  kfpt_pkg::probe_t [kfpt_pkg::NumProbes-1:0] probes,
  input  logic signed [kfpt_pkg::TempW-1:0]          thr,
  input  logic [1:0]                                 rule,
  output logic                                       pass
);

  logic [1:0] valid_cnt;
  logic [1:0] over_cnt;

  always_comb begin
    valid_cnt = 2'd0;
    over_cnt  = 2'd0;
    for (int i = 0; i < kfpt_pkg::NumProbes; i++) begin
      if (probes[i].ok) begin
        valid_cnt = valid_cnt + 2'd1;
        if ($signed(probes[i].temp) >= thr) over_cnt = over_cnt + 2'd1;
      end
    end
  end

  always_comb begin
    if (valid_cnt == 2'd0) begin
      pass = 1'b0;
    end else begin
      case (rule)
        kfpt_pkg::VOTE_ANY: pass = (over_cnt != 2'd0);
        kfpt_pkg::VOTE_ALL: pass = (over_cnt == valid_cnt);
        default:            pass = (over_cnt > (valid_cnt >> 1));
      endcase
    end
  end

endmodule

/* rtl/kfpt_phase.sv */
// kfpt_phase: firing phase machine, run counters and session length
// depends on kfpt_pkg; takes the three vote results from kfpt_vote

module kfpt_phase (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                heat,
  input  logic                act_pass,
  input  logic                cool_pass,
  input  kfpt_pkg::cfg_t      cfg,
  output kfpt_pkg::result_t   res_next
);

  kfpt_pkg::phase_t              phase_reg, phase_reg_next;
  logic [kfpt_pkg::CntW-1:0]     no_heat_run, no_heat_run_next;
  logic [kfpt_pkg::CntW-1:0]     cool_run, cool_run_next;
  logic [kfpt_pkg::CntW-1:0]     cool_inc;
  logic                          session_open, session_open_next;
  logic [kfpt_pkg::TickW-1:0]    session_ticks, session_ticks_next;
  logic [kfpt_pkg::TickW-1:0]    ticks_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= kfpt_pkg::PH_IDLE;
      no_heat_run   <= '0;
      cool_run      <= '0;
      session_open  <= 1'b0;
      session_ticks <= '0;
    end else if (step) begin
      phase_reg     <= phase_reg_next;
      no_heat_run   <= no_heat_run_next;
      cool_run      <= cool_run_next;
      session_open  <= session_open_next;
      session_ticks <= session_ticks_next;
    end
  end

  assign cool_inc  = (&cool_run) ? cool_run : cool_run + 1'b1;
  assign ticks_inc = (&session_ticks) ? session_ticks : session_ticks + 1'b1;

  always_comb begin
    no_heat_run_next   = heat ? '0 : ((&no_heat_run) ? no_heat_run : no_heat_run + 1'b1);
    phase_reg_next     = phase_reg;
    cool_run_next      = cool_run;
    session_open_next  = session_open;
    session_ticks_next = session_ticks;
    unique case (phase_reg)
      kfpt_pkg::PH_IDLE: begin
        if (heat) phase_reg_next = kfpt_pkg::PH_PREHEAT;
        else if (no_heat_run_next >= cfg.rest_to) phase_reg_next = kfpt_pkg::PH_RESTING;
      end
      kfpt_pkg::PH_RESTING: begin
        if (heat) phase_reg_next = kfpt_pkg::PH_PREHEAT;
      end
      kfpt_pkg::PH_PREHEAT: begin
        if (act_pass) begin
          phase_reg_next     = kfpt_pkg::PH_ACTIVE;
          cool_run_next      = '0;
          session_open_next  = 1'b1;
          session_ticks_next = '0;
        end else if (!heat && no_heat_run_next >= cfg.abandon) begin
          phase_reg_next = kfpt_pkg::PH_RESTING;
        end
      end
      kfpt_pkg::PH_ACTIVE: begin
        session_ticks_next = ticks_inc;
        if (!cool_pass) begin
          phase_reg_next = kfpt_pkg::PH_COOLDOWN;
          cool_run_next  = '0;
        end
      end
      kfpt_pkg::PH_COOLDOWN: begin
        session_ticks_next = ticks_inc;
        if (cool_pass) begin
          phase_reg_next = kfpt_pkg::PH_ACTIVE;
          cool_run_next  = '0;
        end else begin
          cool_run_next = cool_inc;
          if (cool_inc >= cfg.cool_need) phase_reg_next = kfpt_pkg::PH_COMPLETE;
        end
      end
      kfpt_pkg::PH_COMPLETE: begin
        session_open_next = 1'b0;
        phase_reg_next    = kfpt_pkg::PH_RESTING;
      end
      default: ;
    endcase
  end

  assign res_next.phase   = phase_reg_next;
  assign res_next.heat    = heat;
  assign res_next.session = session_open_next;
  assign res_next.ticks   = session_ticks_next;

endmodule

/* rtl/kiln_firing_phase_tracker_top.sv */
// kiln_firing_phase_tracker_top: sample register, probe votes, phase update, result register
// depends on kfpt_pkg, kfpt_cfg_regs, kfpt_vote, kfpt_phase
// an accepted sample waits in the sample register, then moves on into the result register
// throughput: one sample per cycle while the result side is not stalled; the phase state
// updates as the sample enters the result register, so the phase machine sets the rate
// reset (rst, synchronous): both stages empty, phase idle, counters and session cleared,
// configuration back to its default values

module kiln_firing_phase_tracker_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [kfpt_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [kfpt_pkg::CfgDataW-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [kfpt_pkg::TempW-1:0]    top_temp,
  input  logic                                 top_ok,
  input  logic signed [kfpt_pkg::TempW-1:0]    middle_temp,
  input  logic                                 middle_ok,
  input  logic signed [kfpt_pkg::TempW-1:0]    bottom_temp,
  input  logic                                 bottom_ok,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           phase,
  output logic                                 heat_seen,
  output logic                                 in_session,
  output logic [kfpt_pkg::TickW-1:0]           session_length
);

  kfpt_pkg::cfg_t                                 cfg;
  kfpt_pkg::probe_t [kfpt_pkg::NumProbes-1:0]     probes;
  logic                                           s1_valid;
  logic                                           s1_advance;
  logic                                           heat, act_pass, cool_pass;
  kfpt_pkg::result_t                              res_next;
  kfpt_pkg::result_t                              res;

  kfpt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sample moves on when the result register is empty or being drained
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      probes[0] <= '{temp: top_temp,    ok: top_ok};
      probes[1] <= '{temp: middle_temp, ok: middle_ok};
      probes[2] <= '{temp: bottom_temp, ok: bottom_ok};
    end
  end

  kfpt_vote u_heat_vote (
    .probes (probes),
    .thr    (cfg.preheat),
    .rule   (kfpt_pkg::VOTE_ANY),
    .pass   (heat)
  );

  kfpt_vote u_act_vote (
    .probes (probes),
    .thr    (cfg.activate),
    .rule   (cfg.rule),
    .pass   (act_pass)
  );

  kfpt_vote u_cool_vote (
    .probes (probes),
    .thr    (cfg.cool),
    .rule   (cfg.rule),
    .pass   (cool_pass)
  );

  kfpt_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_advance),
    .heat      (heat),
    .act_pass  (act_pass),
    .cool_pass (cool_pass),
    .cfg       (cfg),
    .res_next  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) res <= res_next;
  end

  assign phase          = res.phase;
  assign heat_seen      = res.heat;
  assign in_session     = res.session;
  assign session_length = res.ticks;

endmodule

/* rtl/kfpt_checker.sv */
// kfpt_checker: port-level checks of the phase tracker over time, bound to the top level
// depends on kfpt_pkg and kiln_firing_phase_tracker_top

module kfpt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [2:0]                    phase,
  input logic                          heat_seen,
  input logic                          in_session,
  input logic [kfpt_pkg::TickW-1:0]    session_length
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(phase) && $stable(heat_seen)
      && $stable(in_session) && $stable(session_length))
    else $error("stalled result word changed");

  // input side backs up only behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

  // session is open throughout active and cooldown
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase == kfpt_pkg::PH_ACTIVE || phase == kfpt_pkg::PH_COOLDOWN)
      |-> in_session)
    else $error("session closed in active or cooldown");

  // no session outside the firing phases
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase == kfpt_pkg::PH_IDLE || phase == kfpt_pkg::PH_RESTING
      || phase == kfpt_pkg::PH_PREHEAT) |-> !in_session)
    else $error("session open before activation");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word right after reset");

endmodule

bind kiln_firing_phase_tracker_top kfpt_checker u_kfpt_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .phase          (phase),
  .heat_seen      (heat_seen),
  .in_session     (in_session),
  .session_length (session_length)
);
